@@ hdl/sszs_pkg.sv @@
// ----------------------------------------------------------------------------
// sszs_pkg: shared types and constants for the subset sum zero search unit
// Field widths, request codes, controller/datapath command and status
// structures and the mask population count.
// ----------------------------------------------------------------------------
package sszs_pkg;

  localparam int WORD_W  = 64;
  localparam int SLOT_W  = 6;
  localparam int MASK_W  = 32;
  localparam int COUNT_W = 6;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  typedef logic [WORD_W-1:0] word_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // write one table word
    logic start;   // latch bases, clear sweep state
    logic step;    // compare current subset sum, advance to next subset
    logic finish;  // move mask and count to the result register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic last;    // this step visits the final subset
  } status_t;

  // Population count: per byte, then sum the bytes
  function automatic logic [COUNT_W-1:0] popcount(input logic [MASK_W-1:0] m);
    logic [3:0]         part [MASK_W/8];
    logic [COUNT_W-1:0] total;
    for (int j = 0; j < MASK_W/8; j++) begin
      part[j] = '0;
      for (int k = 0; k < 8; k++) begin
        part[j] = part[j] + 4'(m[j*8+k]);
      end
    end
    total = '0;
    for (int j = 0; j < MASK_W/8; j++) begin
      total = total + COUNT_W'(part[j]);
    end
    return total;
  endfunction

endpackage

@@ hdl/sszs_if.sv @@
// ----------------------------------------------------------------------------
// sszs_if: request and response channels of the search unit
// Valid/ready channels; one transfer per edge with valid and ready high.
// ----------------------------------------------------------------------------
interface sszs_req_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [sszs_pkg::SLOT_W-1:0] table_slot;
  logic [sszs_pkg::WORD_W-1:0] value;

  modport source (output valid, output req_type, output table_slot, output value,
                  input ready);
  modport sink   (input valid, input req_type, input table_slot, input value,
                  output ready);
endinterface

interface sszs_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [sszs_pkg::MASK_W-1:0]  found_mask;
  logic [sszs_pkg::COUNT_W-1:0] found_count;

  modport source (output valid, output found_mask, output found_count, input ready);
  modport sink   (input valid, input found_mask, input found_count, output ready);
endinterface

@@ hdl/sszs_ctrl.sv @@
// ----------------------------------------------------------------------------
// sszs_ctrl: sequencer of the search unit
// Accepts requests, runs the subset sweep and hands results to the output
// register.
// ----------------------------------------------------------------------------
module sszs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_is_search,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  output sszs_pkg::cmd_t    cmd,
  input  sszs_pkg::status_t status
);

  typedef enum logic [1:0] {
    IDLE,
    SWEEP,
    FINISH
  } state_t;

  state_t state;

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = in_is_search;
          cmd.load  = !in_is_search;
        end
      end
      SWEEP: begin
        cmd.step = 1'b1;
      end
      FINISH: begin
        cmd.finish = !out_valid || out_ready;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (in_valid && in_is_search) begin
            state <= SWEEP;
          end
        end
        SWEEP: begin
          if (status.last) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          if (cmd.finish) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/sszs_datapath.sv @@
// ----------------------------------------------------------------------------
// sszs_datapath: word table, subset sum walker and comparator lanes
// One lane per prefix offset; the subset sum steps in Gray code order so
// each step adds or subtracts a single subset value.
// ----------------------------------------------------------------------------
module sszs_datapath #(
  parameter int PREFIX_ENTRIES = 32,
  parameter int SUBSET_BITS    = 9
) (
  input  logic                         clk,
  input  sszs_pkg::cmd_t               cmd,
  input  logic [sszs_pkg::SLOT_W-1:0]  table_slot,
  input  logic [sszs_pkg::WORD_W-1:0]  value,
  output sszs_pkg::status_t            status,
  output logic [sszs_pkg::MASK_W-1:0]  found_mask,
  output logic [sszs_pkg::COUNT_W-1:0] found_count
);

  sszs_pkg::word_t             offset  [PREFIX_ENTRIES];
  sszs_pkg::word_t             sub_val [SUBSET_BITS];
  sszs_pkg::word_t             base    [PREFIX_ENTRIES];
  sszs_pkg::word_t             subsum;
  sszs_pkg::word_t             subsum_next;
  sszs_pkg::word_t             sel_val;
  logic [SUBSET_BITS-1:0]      step_cnt;
  logic [SUBSET_BITS-1:0]      step_inc;
  logic [SUBSET_BITS-1:0]      gray;
  logic [SUBSET_BITS-1:0]      flip;
  logic                        dir_sub;
  logic [sszs_pkg::MASK_W-1:0] mask;
  logic [sszs_pkg::MASK_W-1:0] hits;

  // Gray code: the bit to flip is the lowest set bit of the next count
  always_comb begin
    step_inc = step_cnt + SUBSET_BITS'(1);
    flip     = step_inc & ~(step_inc - SUBSET_BITS'(1));
    dir_sub  = |(gray & flip);
    sel_val  = '0;
    for (int i = 0; i < SUBSET_BITS; i++) begin
      if (flip[i]) begin
        sel_val = sel_val | sub_val[i];
      end
    end
    subsum_next = dir_sub ? (subsum - sel_val) : (subsum + sel_val);
  end

  always_comb begin
    hits = '0;
    for (int c = 0; c < PREFIX_ENTRIES; c++) begin
      hits[c] = ((base[c] + subsum) == '0);
    end
  end

  assign status.last = &step_cnt;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int c = 0; c < PREFIX_ENTRIES; c++) begin
        if (table_slot == sszs_pkg::SLOT_W'(c)) begin
          offset[c] <= value;
        end
      end
      for (int i = 0; i < SUBSET_BITS; i++) begin
        if (table_slot == sszs_pkg::SLOT_W'(PREFIX_ENTRIES + i)) begin
          sub_val[i] <= value;
        end
      end
    end
    if (cmd.start) begin
      for (int c = 0; c < PREFIX_ENTRIES; c++) begin
        base[c] <= value + offset[c];
      end
      subsum   <= '0;
      gray     <= '0;
      step_cnt <= '0;
      mask     <= '0;
    end
    if (cmd.step) begin
      mask     <= mask | hits;
      subsum   <= subsum_next;
      gray     <= gray ^ flip;
      step_cnt <= step_inc;
    end
    if (cmd.finish) begin
      found_mask  <= mask;
      found_count <= sszs_pkg::popcount(mask);
    end
  end

endmodule

@@ hdl/subset_sum_zero_search_unit.sv @@
// ----------------------------------------------------------------------------
// subset_sum_zero_search_unit: brute force zero sum subset search
// Holds offset and subset value words; a search reports which prefix
// offsets reach a zero sum with some subset of the subset values.
// ----------------------------------------------------------------------------
//
// Channel  Role    Transfer carries
// -------  ------  ------------------------------------------------------
// req      sink    req_type, table_slot, value (load word / partial sum)
// rsp      source  found_mask, found_count (one per search, none per load)
//
// A load writes its word when accepted. A search forms the per-lane bases,
// then visits one subset per cycle (2^SUBSET_BITS subsets, 512 by default)
// through the PREFIX_ENTRIES adder-comparator lanes, then posts the result.
// Synchronous active-high reset clears the sequencer and the result valid;
// the word table is not cleared and must be loaded before searching.
// A stalled result holds in the output register; a load is still taken
// meanwhile, a following search waits at its end until the register frees.
//
module subset_sum_zero_search_unit #(
  parameter int PREFIX_ENTRIES = 32,
  parameter int SUBSET_BITS    = 9
) (
  input logic       clk,
  input logic       rst,
  sszs_req_if.sink  req,
  sszs_rsp_if.source rsp
);

  sszs_pkg::cmd_t    cmd;
  sszs_pkg::status_t status;

  // Sequencer: request handshake, sweep length, result valid
  sszs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (req.valid),
    .in_is_search (req.req_type == sszs_pkg::REQ_SEARCH),
    .in_ready     (req.ready),
    .out_ready    (rsp.ready),
    .out_valid    (rsp.valid),
    .cmd          (cmd),
    .status       (status)
  );

  // Table, Gray code subset walker and comparator lanes
  sszs_datapath #(
    .PREFIX_ENTRIES (PREFIX_ENTRIES),
    .SUBSET_BITS    (SUBSET_BITS)
  ) u_datapath (
    .clk         (clk),
    .cmd         (cmd),
    .table_slot  (req.table_slot),
    .value       (req.value),
    .status      (status),
    .found_mask  (rsp.found_mask),
    .found_count (rsp.found_count)
  );

endmodule

@@ dv/sszs_tb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sszs_tb_pkg: result predictor and scoreboard for the search unit bench
// Keeps a shadow of the word table, works out the mask and count of every
// accepted search and checks the returned results in order.
// ----------------------------------------------------------------------------
package sszs_tb_pkg;
  import sszs_pkg::*;

  localparam int PREFIX_ENTRIES = 32;
  localparam int SUBSET_BITS    = 9;
  localparam int TABLE_DEPTH    = PREFIX_ENTRIES + SUBSET_BITS;
  localparam int SUBSET_COUNT   = 1 << SUBSET_BITS;

  typedef struct packed {
    logic [MASK_W-1:0]  mask;
    logic [COUNT_W-1:0] count;
  } search_result_t;

  class zero_sum_scoreboard;
    word_t          words [TABLE_DEPTH];
    search_result_t awaited [$];
    int             errors;
    int             loads;
    int             searches;
    int             hit_searches;
    int             hit_prefixes;

    function new();
      errors       = 0;
      loads        = 0;
      searches     = 0;
      hit_searches = 0;
      hit_prefixes = 0;
    endfunction

    // Update the table on a load, or predict the outcome of a search
    function void note_request(logic kind, logic [SLOT_W-1:0] slot, word_t val);
      word_t          sums [SUBSET_COUNT];
      bit             reachable [word_t];
      word_t          need;
      search_result_t res;
      if (kind == REQ_LOAD) begin
        if (slot < TABLE_DEPTH) begin
          words[slot] = val;
          loads++;
        end
        return;
      end
      // every subset sum, built by doubling over the subset values
      sums[0] = '0;
      for (int b = 0; b < SUBSET_BITS; b++) begin
        for (int k = 0; k < (1 << b); k++) begin
          sums[k + (1 << b)] = sums[k] + words[PREFIX_ENTRIES + b];
        end
      end
      for (int k = 0; k < SUBSET_COUNT; k++) begin
        reachable[sums[k]] = 1'b1;
      end
      res = '0;
      for (int c = 0; c < PREFIX_ENTRIES; c++) begin
        need = '0 - val - words[c];
        if (reachable.exists(need)) begin
          res.mask[c] = 1'b1;
        end
      end
      res.count = COUNT_W'($countones(res.mask));
      searches++;
      hit_prefixes += res.count;
      if (res.count != 0) begin
        hit_searches++;
      end
      awaited = {awaited, res};
    endfunction

    function void check_result(logic [MASK_W-1:0] mask, logic [COUNT_W-1:0] count);
      search_result_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got mask %h count %0d",
                 $time, mask, count);
        return;
      end
      want = awaited.pop_front();
      if (mask !== want.mask) begin
        errors++;
        $display("%0t: found_mask mismatch, expected %h, got %h", $time, want.mask, mask);
      end
      if (count !== want.count) begin
        errors++;
        $display("%0t: found_count mismatch, expected %0d, got %0d",
                 $time, want.count, count);
      end
    endfunction
  endclass

endpackage

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: bench for the subset sum zero search unit
// Fills the word table, runs directed searches on a table with known
// answers, then random phases of reloads and searches built to hit zero
// sums, with random idling on both channels and one long response stall.
// ----------------------------------------------------------------------------
module tb_top;
  import sszs_pkg::*;
  import sszs_tb_pkg::*;

  localparam int RANDOM_ITEMS = 1110;
  localparam int DRAIN_CYCLES = 600;      // a little over one full sweep
  localparam int HOLD_OFF     = 3000;     // long response stall, in cycles
  localparam int HOLD_AT      = 40;       // results taken before the stall

  logic clk;
  logic rst;
  bit   gaps_on;

  sszs_req_if req_ch ();
  sszs_rsp_if rsp_ch ();

  zero_sum_scoreboard sb;

  subset_sum_zero_search_unit uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard limit: several times the slowest legal run
  initial begin
    #60_000_000;
    $display("FAIL subset_sum_zero_search_unit");
    $finish;
  end

  // Offer one request. Enter and leave at a falling edge; hold valid high
  // across back-to-back transfers so it is never dropped and raised at once.
  task automatic send_req(logic kind, logic [SLOT_W-1:0] slot, word_t val);
    int gap;
    gap = gaps_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid      = 1'b1;
    req_ch.req_type   = kind;
    req_ch.table_slot = slot;
    req_ch.value      = val;
    do @(posedge clk); while (!req_ch.ready);
    // transfer taken at this edge: let the predictor see it in order
    sb.note_request(kind, slot, val);
    @(negedge clk);
  endtask

  // Sum of the subset values picked by m, as the table stands now
  function automatic word_t subset_total(logic [SUBSET_BITS-1:0] m);
    word_t acc;
    acc = '0;
    for (int b = 0; b < SUBSET_BITS; b++) begin
      if (m[b]) begin
        acc = acc + sb.words[PREFIX_ENTRIES + b];
      end
    end
    return acc;
  endfunction

  // Small signed values make matches dense; wide ones make them rare
  function automatic word_t draw_word(bit dense);
    word_t w;
    case ($urandom_range(0, 19))
      0: w = '0;
      1: w = '1;
      2: w = {1'b1, {(WORD_W-1){1'b0}}};
      3: w = {1'b0, {(WORD_W-1){1'b1}}};
      default: begin
        if (dense) begin
          w = word_t'($urandom_range(0, 32));
          w = w - 16;
        end else begin
          w = {$urandom, $urandom};
        end
      end
    endcase
    return w;
  endfunction

  // Response side: random hold-off per result, one long stall, check on
  // every transfer sampled at the rising edge
  initial begin
    int wait_n;
    int taken;
    taken        = 0;
    rsp_ch.ready = 1'b0;
    do @(negedge clk); while (rst);
    forever begin
      wait_n = gaps_on ? $urandom_range(0, 19) : 0;
      if (taken == HOLD_AT) begin
        wait_n = HOLD_OFF;
      end
      if (wait_n > 0) begin
        rsp_ch.ready = 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      rsp_ch.ready = 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      sb.check_result(rsp_ch.found_mask, rsp_ch.found_count);
      taken++;
      @(negedge clk);
    end
  end

  // Main stimulus
  initial begin
    int          counted;
    int          n_loads;
    int          n_search;
    int          c;
    bit          dense;
    logic [SUBSET_BITS-1:0] m;
    word_t       s;

    sb                = new();
    gaps_on           = 1'b1;
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.req_type   = REQ_LOAD;
    req_ch.table_slot = '0;
    req_ch.value      = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Fill the whole table before any search: offsets 10*c, subset values
    // the powers of two, so every sum from 0 to 511 is reachable
    for (int k = 0; k < PREFIX_ENTRIES; k++) begin
      send_req(REQ_LOAD, SLOT_W'(k), word_t'(10 * k));
    end
    for (int b = 0; b < SUBSET_BITS; b++) begin
      send_req(REQ_LOAD, SLOT_W'(PREFIX_ENTRIES + b), word_t'(1) << b);
    end

    // Directed: only prefix 0 matches, then all 32, then the top three
    send_req(REQ_SEARCH, '0, '0);
    send_req(REQ_SEARCH, '1, '0 - 320);
    send_req(REQ_SEARCH, 6'd17, '0 - 800);
    // extreme partial sums
    send_req(REQ_SEARCH, '0, {1'b0, {(WORD_W-1){1'b1}}});
    send_req(REQ_SEARCH, '1, {1'b1, {(WORD_W-1){1'b0}}});
    // loads past the end of the table must leave it untouched
    send_req(REQ_LOAD, SLOT_W'(TABLE_DEPTH), '1);
    send_req(REQ_LOAD, '1, '0);
    send_req(REQ_SEARCH, '0, '0 - 320);
    // wraparound: max positive offset plus min negative plus one is zero
    send_req(REQ_LOAD, 6'd5, {1'b0, {(WORD_W-1){1'b1}}});
    send_req(REQ_SEARCH, '0, {1'b1, {(WORD_W-2){1'b0}}, 1'b1});
    // two min-negative subset values cancel modulo 2^64
    send_req(REQ_LOAD, SLOT_W'(TABLE_DEPTH - 1), {1'b1, {(WORD_W-1){1'b0}}});
    send_req(REQ_LOAD, SLOT_W'(TABLE_DEPTH - 2), {1'b1, {(WORD_W-1){1'b0}}});
    send_req(REQ_SEARCH, '0, '0 - 100);
    send_req(REQ_LOAD, 6'd0, '1);
    send_req(REQ_SEARCH, '1, 64'd1);
    send_req(REQ_SEARCH, '0, {1'b1, {(WORD_W-1){1'b0}}});

    // Random phases: reload a few words, then searches mostly aimed at a
    // chosen prefix and subset so the sweep finds something
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      dense   = 1'($urandom_range(0, 1));
      n_loads = $urandom_range(1, 10);
      repeat (n_loads) begin
        if ($urandom_range(0, 9) == 0) begin
          send_req(REQ_LOAD, SLOT_W'($urandom_range(TABLE_DEPTH, 63)), draw_word(dense));
        end else begin
          send_req(REQ_LOAD, SLOT_W'($urandom_range(0, TABLE_DEPTH - 1)), draw_word(dense));
        end
        counted++;
      end
      n_search = $urandom_range(1, 5);
      repeat (n_search) begin
        if ($urandom_range(0, 9) < 7) begin
          c = $urandom_range(0, PREFIX_ENTRIES - 1);
          m = SUBSET_BITS'($urandom_range(0, SUBSET_COUNT - 1));
          s = '0 - sb.words[c] - subset_total(m);
        end else begin
          s = draw_word(1'($urandom_range(0, 1)));
        end
        send_req(REQ_SEARCH, SLOT_W'($urandom_range(0, 63)), s);
        counted++;
      end
    end
    req_ch.valid = 1'b0;
    gaps_on      = 1'b0;

    // Drain: wait for every awaited result, then watch for strays
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d table loads and %0d searches.", sb.loads, sb.searches);
    $display("%0d searches found zero sums, %0d matching prefixes in all.",
             sb.hit_searches, sb.hit_prefixes);
    if (sb.errors == 0) begin
      $display("PASS subset_sum_zero_search_unit");
    end else begin
      $display("FAIL subset_sum_zero_search_unit");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/sszs_pkg.sv
hdl/sszs_if.sv
hdl/sszs_ctrl.sv
hdl/sszs_datapath.sv
hdl/subset_sum_zero_search_unit.sv
dv/sszs_tb_pkg.sv
dv/tb_top.sv
